@@ rtl/core/jsu_pkg.sv @@
// jsu_pkg: shared types, codes and decode functions for the json string unescaper
// no dependencies; used by json_string_unescape_top
package jsu_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned AccW    = 12;
  localparam int unsigned MaxRes  = 3;
  localparam int unsigned CntW    = 2;

  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [CntW-1:0]    cnt_t;
  typedef logic [AccW-1:0]    acc_t;

  localparam status_t StData      = 2'd0;
  localparam status_t StBadLetter = 2'd1;
  localparam status_t StBadHex    = 2'd2;
  localparam status_t StTruncated = 2'd3;

  localparam byte_t ChBackslash = 8'h5C;
  localparam byte_t ChU         = 8'h75;

  // parse modes, one-hot
  typedef enum logic [5:0] {
    MODE_NORMAL = 6'b000001,
    MODE_ESCAPE = 6'b000010,
    MODE_HEX1   = 6'b000100,
    MODE_HEX2   = 6'b001000,
    MODE_HEX3   = 6'b010000,
    MODE_HEX4   = 6'b100000
  } mode_t;

  typedef struct packed {
    logic  ok;
    byte_t value;
  } esc_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  typedef struct packed {
    byte_t   data;
    status_t status;
  } slot_t;

  // single-byte escape letters
  function automatic esc_t escape_byte(input byte_t c);
    esc_t r;
    r.ok = 1'b1;
    case (c)
      8'h74:   r.value = 8'h09; // t
      8'h72:   r.value = 8'h0D; // r
      8'h6E:   r.value = 8'h0A; // n
      8'h62:   r.value = 8'h08; // b
      8'h66:   r.value = 8'h0C; // f
      8'h30:   r.value = 8'h00; // 0
      8'h5C:   r.value = 8'h5C; // backslash
      8'h2F:   r.value = 8'h2F; // slash
      8'h22:   r.value = 8'h22; // quote
      default: begin
        r.ok    = 1'b0;
        r.value = 8'h00;
      end
    endcase
    return r;
  endfunction

  // hex digit of either case
  function automatic hex_t hex_value(input byte_t c);
    hex_t r;
    r.ok    = 1'b1;
    r.value = 4'h0;
    if (c inside {[8'h30:8'h39]}) begin
      r.value = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r.value = c[3:0] + 4'd9;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/json_string_unescape_top.sv @@
// json_string_unescape_top: streaming unescaper for json-style string text
// depends on jsu_pkg for codes, types and the escape and hex decode functions
//
//  channel | ports                                               | direction
//  --------+-----------------------------------------------------+----------
//  in      | in_valid, in_stall, in_text_byte, in_string_end     | request in
//  out     | out_valid, out_stall, out_byte, out_status,         | request out
//          | out_run_last, out_string_done                       |
//
// one input request is decoded in the cycle it is accepted; its 0..3 results
// are loaded into a three-slot result buffer and leave one per cycle while
// out_stall is low. a byte giving one result sustains one request per cycle
// while out_stall is low; a two- or three-byte utf-8 run holds in_stall until
// the single output port has drained the result buffer to its last result.
// reset (rst_n low, synchronous) returns to normal text mode with no results
// pending. in_stall follows out_stall while the last buffered result waits.
module json_string_unescape_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  jsu_pkg::byte_t       in_text_byte,
  input  logic                 in_string_end,
  output logic                 out_valid,
  input  logic                 out_stall,
  output jsu_pkg::byte_t       out_byte,
  output jsu_pkg::status_t     out_status,
  output logic                 out_run_last,
  output logic                 out_string_done
);

  // parser state
  jsu_pkg::mode_t mode_r, mode_nxt;
  jsu_pkg::acc_t  acc_r, acc_nxt;

  // result buffer: slot 0 is presented, later slots shift down
  jsu_pkg::slot_t slot_r [jsu_pkg::MaxRes];
  jsu_pkg::slot_t slot_nxt [jsu_pkg::MaxRes];
  jsu_pkg::cnt_t  rem_r, rem_nxt;
  logic           end_r, end_nxt;

  // decode of the incoming request
  jsu_pkg::slot_t dec_slot [jsu_pkg::MaxRes];
  jsu_pkg::cnt_t  dec_cnt;
  jsu_pkg::mode_t dec_mode;
  jsu_pkg::acc_t  dec_acc;
  jsu_pkg::esc_t  esc;
  jsu_pkg::hex_t  hex;
  logic [15:0]    cp;

  logic in_take, out_take;

  assign out_valid       = (rem_r != '0);
  assign out_take        = out_valid && !out_stall;
  // accept when the buffer is empty or its last result leaves this cycle
  assign in_stall        = (rem_r > jsu_pkg::cnt_t'(1)) ||
                           ((rem_r == jsu_pkg::cnt_t'(1)) && out_stall);
  assign in_take         = in_valid && !in_stall;

  assign out_byte        = slot_r[0].data;
  assign out_status      = slot_r[0].status;
  assign out_run_last    = (rem_r == jsu_pkg::cnt_t'(1));
  assign out_string_done = out_run_last && end_r;

  assign esc = jsu_pkg::escape_byte(in_text_byte);
  assign hex = jsu_pkg::hex_value(in_text_byte);
  assign cp  = {acc_r, hex.value};

  // one pass of the escape parser
  always_comb begin
    for (int i = 0; i < jsu_pkg::MaxRes; i++) begin
      dec_slot[i] = '{data: '0, status: jsu_pkg::StData};
    end
    dec_cnt  = '0;
    dec_mode = jsu_pkg::MODE_NORMAL;
    dec_acc  = '0;
    case (mode_r)
      jsu_pkg::MODE_ESCAPE: begin
        if (in_text_byte == jsu_pkg::ChU) begin
          if (in_string_end) begin
            dec_slot[0].status = jsu_pkg::StTruncated;
            dec_cnt            = jsu_pkg::cnt_t'(1);
          end else begin
            dec_mode = jsu_pkg::MODE_HEX1;
          end
        end else if (esc.ok) begin
          dec_slot[0].data = esc.value;
          dec_cnt          = jsu_pkg::cnt_t'(1);
        end else begin
          dec_slot[0].status = jsu_pkg::StBadLetter;
          dec_cnt            = jsu_pkg::cnt_t'(1);
        end
      end
      jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3: begin
        if (in_string_end) begin
          dec_slot[0].status = jsu_pkg::StTruncated;
          dec_cnt            = jsu_pkg::cnt_t'(1);
        end else if (!hex.ok) begin
          dec_slot[0].status = jsu_pkg::StBadHex;
          dec_cnt            = jsu_pkg::cnt_t'(1);
        end else begin
          dec_acc = {acc_r[7:0], hex.value};
          case (mode_r)
            jsu_pkg::MODE_HEX1: dec_mode = jsu_pkg::MODE_HEX2;
            jsu_pkg::MODE_HEX2: dec_mode = jsu_pkg::MODE_HEX3;
            default:            dec_mode = jsu_pkg::MODE_HEX4;
          endcase
        end
      end
      jsu_pkg::MODE_HEX4: begin
        if (!hex.ok) begin
          dec_slot[0].status = jsu_pkg::StBadHex;
          dec_cnt            = jsu_pkg::cnt_t'(1);
        end else if (cp[15:7] == '0) begin
          dec_slot[0].data = {1'b0, cp[6:0]};
          dec_cnt          = jsu_pkg::cnt_t'(1);
        end else if (cp[15:11] == '0) begin
          dec_slot[0].data = {3'b110, cp[10:6]};
          dec_slot[1].data = {2'b10, cp[5:0]};
          dec_cnt          = jsu_pkg::cnt_t'(2);
        end else begin
          dec_slot[0].data = {4'b1110, cp[15:12]};
          dec_slot[1].data = {2'b10, cp[11:6]};
          dec_slot[2].data = {2'b10, cp[5:0]};
          dec_cnt          = jsu_pkg::cnt_t'(3);
        end
      end
      default: begin
        // normal text, also any stray mode code
        if (in_text_byte == jsu_pkg::ChBackslash) begin
          if (in_string_end) begin
            dec_slot[0].status = jsu_pkg::StTruncated;
            dec_cnt            = jsu_pkg::cnt_t'(1);
          end else begin
            dec_mode = jsu_pkg::MODE_ESCAPE;
          end
        end else begin
          dec_slot[0].data = in_text_byte;
          dec_cnt          = jsu_pkg::cnt_t'(1);
        end
      end
    endcase
    // end of string always leaves the parser in normal mode
    if (in_string_end) begin
      dec_mode = jsu_pkg::MODE_NORMAL;
      dec_acc  = '0;
    end
  end

  // buffer and state next values
  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    end_nxt  = end_r;
    for (int i = 0; i < jsu_pkg::MaxRes; i++) begin
      slot_nxt[i] = slot_r[i];
    end
    if (out_take) begin
      for (int i = 0; i < jsu_pkg::MaxRes - 1; i++) begin
        slot_nxt[i] = slot_r[i+1];
      end
      rem_nxt = rem_r - jsu_pkg::cnt_t'(1);
    end
    if (in_take) begin
      mode_nxt = dec_mode;
      acc_nxt  = dec_acc;
      rem_nxt  = dec_cnt;
      end_nxt  = in_string_end;
      for (int i = 0; i < jsu_pkg::MaxRes; i++) begin
        slot_nxt[i] = dec_slot[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jsu_pkg::MODE_NORMAL;
      acc_r  <= '0;
      rem_r  <= '0;
      end_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      rem_r  <= rem_nxt;
      end_r  <= end_nxt;
    end
  end

  // payload slots need no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < jsu_pkg::MaxRes; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

endmodule
